/* rtl/core/qvr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  localparam int unsigned ACC_MAX_W = 64;

  function automatic int unsigned acc_width(input int unsigned w);
    acc_width = (w > ACC_MAX_W) ? ACC_MAX_W : w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/qvr_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface qvr_in_if #(
  parameter int unsigned VW = 16,
  parameter int unsigned QW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] vec_x;
  logic signed [VW-1:0] vec_y;
  logic signed [VW-1:0] vec_z;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;

  modport source (
    output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
    input  ready
  );

  modport sink (
    input  valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/qvr_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface qvr_out_if #(
  parameter int unsigned VW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] rot_x;
  logic signed [VW-1:0] rot_y;
  logic signed [VW-1:0] rot_z;
  logic                 clipped;

  modport source (
    output valid, rot_x, rot_y, rot_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, clipped,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/quaternion_vector_rotate.sv */
`timescale 1ns / 1ps
`default_nettype none

// Rotates a signed integer vector by a Q1.QUAT_FRAC_BITS quaternion as q * (0, v) * conj(q),
// rounding after each Hamilton product and saturating the result, with clipped set when any
// component saturated. A quaternion that is not of unit length scales the result by its
// squared norm. The block takes one item per cycle while the output is not stalled: each
// Hamilton product takes one multiplier stage and one add-and-round stage, and a final
// stage saturates into the output register. A stall on the output holds every stage that
// holds an item in place, and since the ready path runs straight through all stages, an item
// can enter in the same cycle in which the stall clears.
module quaternion_vector_rotate #(
  parameter int unsigned VEC_WIDTH      = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  qvr_in_if.sink    in_ch,
  qvr_out_if.source out_ch
);
  import qvr_pkg::*;

  localparam int unsigned QW = QUAT_FRAC_BITS + 2;
  localparam int unsigned PW = acc_width(QW + VEC_WIDTH + 1) - QUAT_FRAC_BITS;
  localparam int unsigned RW = acc_width(PW + QW + 2) - QUAT_FRAC_BITS;

  logic signed [VEC_WIDTH-1:0] vec   [3];
  logic signed [QW-1:0]        quat  [4];
  logic signed [PW-1:0]        p     [4];
  logic signed [QW-1:0]        quat2 [4];
  logic signed [RW-1:0]        r     [3];
  logic signed [VEC_WIDTH-1:0] rot   [3];
  logic                        p_valid;
  logic                        p_ready;
  logic                        r_valid;
  logic                        r_ready;

  assign vec[0]  = in_ch.vec_x;
  assign vec[1]  = in_ch.vec_y;
  assign vec[2]  = in_ch.vec_z;
  assign quat[0] = in_ch.quat_w;
  assign quat[1] = in_ch.quat_x;
  assign quat[2] = in_ch.quat_y;
  assign quat[3] = in_ch.quat_z;

  qvr_fwd_prod #(
    .VW (VEC_WIDTH),
    .QF (QUAT_FRAC_BITS)
  ) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .vec_i     (vec),
    .quat_i    (quat),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .p_o       (p),
    .quat_o    (quat2)
  );

  qvr_conj_prod #(
    .PW (PW),
    .QF (QUAT_FRAC_BITS)
  ) u_conj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .p_i       (p),
    .quat_i    (quat2),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .r_o       (r)
  );

  qvr_sat #(
    .VW (VEC_WIDTH),
    .RW (RW)
  ) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .r_i       (r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .rot_o     (rot),
    .clip_o    (out_ch.clipped)
  );

  assign out_ch.rot_x = rot[0];
  assign out_ch.rot_y = rot[1];
  assign out_ch.rot_z = rot[2];

endmodule

`default_nettype wire

/* rtl/core/qvr_fwd_prod.sv */
`timescale 1ns / 1ps
`default_nettype none

module qvr_fwd_prod #(
  parameter int unsigned VW = 16,
  parameter int unsigned QF = 14,
  localparam int unsigned QW = QF + 2,
  localparam int unsigned PW = qvr_pkg::acc_width(QW + VW + 1) - QF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] vec_i  [3],
  input  logic signed [QW-1:0] quat_i [4],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [PW-1:0] p_o    [4],
  output logic signed [QW-1:0] quat_o [4]
);
  import qvr_pkg::*;

  localparam int unsigned MW = QW + VW;
  localparam int unsigned AW = acc_width(MW + 1);
  localparam logic signed [AW-1:0] RND = AW'(1) << (QF - 1);

  logic                 m_vld_r;
  logic signed [MW-1:0] prod_r   [12];
  logic signed [MW-1:0] prod_nxt [12];
  logic signed [QW-1:0] q1_r     [4];
  logic                 s_vld_r;
  logic signed [PW-1:0] p_r      [4];
  logic signed [PW-1:0] p_nxt    [4];
  logic signed [QW-1:0] q2_r     [4];
  logic signed [AW-1:0] sum      [4];
  logic                 en1;
  logic                 en2;

  assign en2      = !s_vld_r || out_ready;
  assign en1      = !m_vld_r || en2;
  assign in_ready = en1;

  always_comb begin
    prod_nxt[0]  = MW'(quat_i[1]) * MW'(vec_i[0]);
    prod_nxt[1]  = MW'(quat_i[2]) * MW'(vec_i[1]);
    prod_nxt[2]  = MW'(quat_i[3]) * MW'(vec_i[2]);
    prod_nxt[3]  = MW'(quat_i[0]) * MW'(vec_i[0]);
    prod_nxt[4]  = MW'(quat_i[2]) * MW'(vec_i[2]);
    prod_nxt[5]  = MW'(quat_i[3]) * MW'(vec_i[1]);
    prod_nxt[6]  = MW'(quat_i[0]) * MW'(vec_i[1]);
    prod_nxt[7]  = MW'(quat_i[1]) * MW'(vec_i[2]);
    prod_nxt[8]  = MW'(quat_i[3]) * MW'(vec_i[0]);
    prod_nxt[9]  = MW'(quat_i[0]) * MW'(vec_i[2]);
    prod_nxt[10] = MW'(quat_i[1]) * MW'(vec_i[1]);
    prod_nxt[11] = MW'(quat_i[2]) * MW'(vec_i[0]);
  end

  always_comb begin
    sum[0] = RND - AW'(prod_r[0]) - AW'(prod_r[1]) - AW'(prod_r[2]);
    sum[1] = RND + AW'(prod_r[3]) + AW'(prod_r[4]) - AW'(prod_r[5]);
    sum[2] = RND + AW'(prod_r[6]) - AW'(prod_r[7]) + AW'(prod_r[8]);
    sum[3] = RND + AW'(prod_r[9]) + AW'(prod_r[10]) - AW'(prod_r[11]);
    for (int k = 0; k < 4; k++) begin
      p_nxt[k] = sum[k][AW-1:QF];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      if (en1) begin
        m_vld_r <= in_valid;
      end
      if (en2) begin
        s_vld_r <= m_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      prod_r <= prod_nxt;
      q1_r   <= quat_i;
    end
    if (en2 && m_vld_r) begin
      p_r  <= p_nxt;
      q2_r <= q1_r;
    end
  end

  assign out_valid = s_vld_r;
  assign p_o       = p_r;
  assign quat_o    = q2_r;

endmodule

`default_nettype wire

/* rtl/core/qvr_conj_prod.sv */
`timescale 1ns / 1ps
`default_nettype none

module qvr_conj_prod #(
  parameter int unsigned PW = 21,
  parameter int unsigned QF = 14,
  localparam int unsigned QW = QF + 2,
  localparam int unsigned RW = qvr_pkg::acc_width(PW + QW + 2) - QF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [PW-1:0] p_i    [4],
  input  logic signed [QW-1:0] quat_i [4],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [RW-1:0] r_o    [3]
);
  import qvr_pkg::*;

  localparam int unsigned FW = PW + QW;
  localparam int unsigned MT = acc_width(FW);
  localparam int unsigned AW = acc_width(FW + 2);
  localparam logic signed [AW-1:0] RND = AW'(1) << (QF - 1);

  logic                 m_vld_r;
  logic signed [FW-1:0] full     [12];
  logic signed [MT-1:0] prod_r   [12];
  logic signed [MT-1:0] prod_nxt [12];
  logic                 s_vld_r;
  logic signed [RW-1:0] r_r      [3];
  logic signed [RW-1:0] r_nxt    [3];
  logic signed [AW-1:0] sum      [3];
  logic                 en1;
  logic                 en2;

  assign en2      = !s_vld_r || out_ready;
  assign en1      = !m_vld_r || en2;
  assign in_ready = en1;

  always_comb begin
    full[0]  = FW'(p_i[0]) * FW'(quat_i[1]);
    full[1]  = FW'(p_i[1]) * FW'(quat_i[0]);
    full[2]  = FW'(p_i[2]) * FW'(quat_i[3]);
    full[3]  = FW'(p_i[3]) * FW'(quat_i[2]);
    full[4]  = FW'(p_i[0]) * FW'(quat_i[2]);
    full[5]  = FW'(p_i[1]) * FW'(quat_i[3]);
    full[6]  = FW'(p_i[2]) * FW'(quat_i[0]);
    full[7]  = FW'(p_i[3]) * FW'(quat_i[1]);
    full[8]  = FW'(p_i[0]) * FW'(quat_i[3]);
    full[9]  = FW'(p_i[1]) * FW'(quat_i[2]);
    full[10] = FW'(p_i[2]) * FW'(quat_i[1]);
    full[11] = FW'(p_i[3]) * FW'(quat_i[0]);
    for (int k = 0; k < 12; k++) begin
      prod_nxt[k] = full[k][MT-1:0];
    end
  end

  always_comb begin
    sum[0] = RND - AW'(prod_r[0]) + AW'(prod_r[1]) - AW'(prod_r[2]) + AW'(prod_r[3]);
    sum[1] = RND - AW'(prod_r[4]) + AW'(prod_r[5]) + AW'(prod_r[6]) - AW'(prod_r[7]);
    sum[2] = RND - AW'(prod_r[8]) - AW'(prod_r[9]) + AW'(prod_r[10]) + AW'(prod_r[11]);
    for (int k = 0; k < 3; k++) begin
      r_nxt[k] = sum[k][AW-1:QF];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      if (en1) begin
        m_vld_r <= in_valid;
      end
      if (en2) begin
        s_vld_r <= m_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (en2 && m_vld_r) begin
      r_r <= r_nxt;
    end
  end

  assign out_valid = s_vld_r;
  assign r_o       = r_r;

endmodule

`default_nettype wire

/* rtl/core/qvr_sat.sv */
`timescale 1ns / 1ps
`default_nettype none

module qvr_sat #(
  parameter int unsigned VW = 16,
  parameter int unsigned RW = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [RW-1:0] r_i   [3],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VW-1:0] rot_o [3],
  output logic                 clip_o
);
  localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW - 1){1'b0}}};

  logic                 vld_r;
  logic signed [VW-1:0] rot_r   [3];
  logic signed [VW-1:0] rot_nxt [3];
  logic                 clip_r;
  logic                 clip_nxt;
  logic [RW-VW:0]       top_bits [3];
  logic [2:0]           over;
  logic                 en;

  assign en       = !vld_r || out_ready;
  assign in_ready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      top_bits[k] = r_i[k][RW-1:VW-1];
      over[k]     = !((&top_bits[k]) || !(|top_bits[k]));
      if (over[k]) begin
        rot_nxt[k] = r_i[k][RW-1] ? SAT_MIN : SAT_MAX;
      end else begin
        rot_nxt[k] = r_i[k][VW-1:0];
      end
    end
    clip_nxt = |over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid = vld_r;
  assign rot_o     = rot_r;
  assign clip_o    = clip_r;

endmodule

`default_nettype wire

/* test/quaternion_vector_rotate_checker.sv */
`timescale 1ns / 1ps

module quaternion_vector_rotate_checker #(
  parameter int unsigned VEC_WIDTH      = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  qvr_in_if    in_ch,
  qvr_out_if   out_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [63:0] w;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] x;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [VEC_WIDTH-1:0] z;
    logic                        clipped;
  } rot_t;

  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [63:0] VEC_MAX    = (64'sd1 <<< (VEC_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VEC_MIN    = -VEC_MAX - 64'sd1;

  rot_t expected_rot_q[$];
  rot_t want;
  rot_t got;
  quat_t q_in;
  quat_t v_in;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic signed [63:0] round_frac(logic signed [63:0] t);
    return (t + ROUND_HALF) >>> QUAT_FRAC_BITS;
  endfunction

  function automatic quat_t hamilton_round(quat_t a, quat_t b);
    quat_t c;
    c.w = round_frac(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
    c.x = round_frac(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
    c.y = round_frac(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
    c.z = round_frac(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
    return c;
  endfunction

  function automatic logic out_of_range(logic signed [63:0] v);
    return (v > VEC_MAX) || (v < VEC_MIN);
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] clamp(logic signed [63:0] v);
    logic signed [63:0] lim;
    lim = (v > VEC_MAX) ? VEC_MAX : ((v < VEC_MIN) ? VEC_MIN : v);
    return lim[VEC_WIDTH-1:0];
  endfunction

  function automatic rot_t rotate_vector(quat_t q, quat_t v);
    quat_t qc;
    quat_t p;
    quat_t r;
    rot_t  res;
    qc   = q;
    qc.x = -q.x;
    qc.y = -q.y;
    qc.z = -q.z;
    p = hamilton_round(q, v);
    r = hamilton_round(p, qc);
    res.x       = clamp(r.x);
    res.y       = clamp(r.y);
    res.z       = clamp(r.z);
    res.clipped = out_of_range(r.x) | out_of_range(r.y) | out_of_range(r.z);
    return res;
  endfunction

  task automatic report(input string what);
    $display("%0t ns: %s", $time, what);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.x       = out_ch.rot_x;
        got.y       = out_ch.rot_y;
        got.z       = out_ch.rot_z;
        got.clipped = out_ch.clipped;
        if (expected_rot_q.size() == 0) begin
          report($sformatf("result (%0d, %0d, %0d, clipped %0b) with no item outstanding",
                           got.x, got.y, got.z, got.clipped));
        end else begin
          want = expected_rot_q.pop_front();
          if (got.x !== want.x)
            report($sformatf("rot_x is %0d, expected %0d", got.x, want.x));
          if (got.y !== want.y)
            report($sformatf("rot_y is %0d, expected %0d", got.y, want.y));
          if (got.z !== want.z)
            report($sformatf("rot_z is %0d, expected %0d", got.z, want.z));
          if (got.clipped !== want.clipped)
            report($sformatf("clipped is %0b, expected %0b", got.clipped, want.clipped));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        q_in.w = in_ch.quat_w;
        q_in.x = in_ch.quat_x;
        q_in.y = in_ch.quat_y;
        q_in.z = in_ch.quat_z;
        v_in.w = '0;
        v_in.x = in_ch.vec_x;
        v_in.y = in_ch.vec_y;
        v_in.z = in_ch.vec_z;
        expected_rot_q.push_back(rotate_vector(q_in, v_in));
      end
    end
    pending <= expected_rot_q.size();
  end

endmodule

/* test/quaternion_vector_rotate_test.sv */
`timescale 1ns / 1ps

module quaternion_vector_rotate_test;

  localparam int unsigned VW  = 16;
  localparam int unsigned QFB = 14;
  localparam int unsigned QW  = QFB + 2;

  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FULL_RATE
  } phase_t;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vz;
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
  } rot_req_t;

  logic   clk;
  logic   rst_n;
  phase_t phase;
  int     errors;
  int     pending;
  int     idle_cycles;

  qvr_in_if #(.VW(VW), .QW(QW)) in_ch ();
  qvr_out_if #(.VW(VW)) out_ch ();

  quaternion_vector_rotate #(
    .VEC_WIDTH     (VW),
    .QUAT_FRAC_BITS(QFB)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  quaternion_vector_rotate_checker #(
    .VEC_WIDTH     (VW),
    .QUAT_FRAC_BITS(QFB)
  ) u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int source_idle_pct();
    case (phase)
      PH_SLOW_SINK:   return 16;
      PH_SLOW_SOURCE: return 66;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_idle_pct();
    case (phase)
      PH_SLOW_SINK:   return 66;
      PH_SLOW_SOURCE: return 16;
      default:        return 0;
    endcase
  endfunction

  function automatic rot_req_t req(int vx, int vy, int vz, int qw, int qx, int qy, int qz);
    rot_req_t r;
    r.vx = vx[VW-1:0];
    r.vy = vy[VW-1:0];
    r.vz = vz[VW-1:0];
    r.qw = qw[QW-1:0];
    r.qx = qx[QW-1:0];
    r.qy = qy[QW-1:0];
    r.qz = qz[QW-1:0];
    return r;
  endfunction

  function automatic logic signed [VW-1:0] random_vec_comp(bit narrow);
    if (narrow)
      return VW'(int'($urandom_range(0, 400)) - 200);
    return VW'($urandom());
  endfunction

  function automatic logic signed [QW-1:0] random_quat_comp(bit wide);
    if (wide)
      return QW'($urandom());
    return QW'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  // Most quaternions are near-unit, from a few fixed rotations rotated cyclically across
  // the components and with random signs; the rest have random components.
  function automatic rot_req_t random_request();
    rot_req_t r;
    logic [4*QW-1:0] base;
    logic signed [QW-1:0] c [4];
    int mode;
    int k;
    mode = $urandom_range(0, 99);
    r.vx = random_vec_comp(mode >= 50 && mode < 65);
    r.vy = random_vec_comp(mode >= 50 && mode < 65);
    r.vz = random_vec_comp(mode >= 50 && mode < 65);
    if (mode < 65) begin
      case ($urandom_range(0, 5))
        0:       base = {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        1:       base = {16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
        2:       base = {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
        3:       base = {16'sd15826, 16'sd4240, 16'sd0, 16'sd0};
        4:       base = {16'sd14189, 16'sd8192, 16'sd0, 16'sd0};
        default: base = {16'sd9459, 16'sd9459, 16'sd9459, 16'sd0};
      endcase
      k = $urandom_range(0, 3);
      base = (base >> (QW * k)) | (base << (4 * QW - QW * k));
      for (int i = 0; i < 4; i++) begin
        c[i] = base[QW*i +: QW];
        if ($urandom_range(0, 1))
          c[i] = -c[i];
      end
      r.qw = c[0];
      r.qx = c[1];
      r.qy = c[2];
      r.qz = c[3];
    end else begin
      r.qw = random_quat_comp(mode >= 90);
      r.qx = random_quat_comp(mode >= 90);
      r.qy = random_quat_comp(mode >= 90);
      r.qz = random_quat_comp(mode >= 90);
    end
    return r;
  endfunction

  task automatic send_item(input rot_req_t item);
    while ($urandom_range(0, 99) < source_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.vec_x  <= item.vx;
    in_ch.vec_y  <= item.vy;
    in_ch.vec_z  <= item.vz;
    in_ch.quat_w <= item.qw;
    in_ch.quat_x <= item.qx;
    in_ch.quat_y <= item.qy;
    in_ch.quat_z <= item.qz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // The sink stalls once for a long stretch when full rate begins, so that
  // the pipeline fills and the input side has to wait.
  initial begin : sink_side
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_FULL_RATE && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct());
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    phase        <= PH_SLOW_SINK;
    idle_cycles  <= 0;
    in_ch.valid  <= 1'b0;
    in_ch.vec_x  <= '0;
    in_ch.vec_y  <= '0;
    in_ch.vec_z  <= '0;
    in_ch.quat_w <= '0;
    in_ch.quat_x <= '0;
    in_ch.quat_y <= '0;
    in_ch.quat_z <= '0;
    out_ch.ready <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(req(0, 0, 0, 16384, 0, 0, 0));
    send_item(req(32767, -32768, 1, 16384, 0, 0, 0));
    send_item(req(-32768, -32768, -32768, 16384, 0, 0, 0));
    send_item(req(32767, 32767, 32767, 11585, 0, 0, 11585));
    send_item(req(1000, 0, 0, 11585, 0, 0, 11585));
    send_item(req(0, 1000, 0, 11585, 11585, 0, 0));
    send_item(req(12345, -222, 7, 0, 0, 16384, 0));
    send_item(req(-32768, 5, 32767, -16384, 0, 0, 0));
    send_item(req(100, 200, 300, 8192, 8192, 8192, 8192));
    send_item(req(3, -3, 1, 8192, 0, 0, 0));
    send_item(req(-5, 7, -9, 0, 8192, 0, 0));
    send_item(req(20000, -20000, 100, 16384, 16384, 16384, 16384));
    send_item(req(32767, -32768, 0, -16384, -16384, -16384, -16384));
    send_item(req(32767, 32767, -32768, 0, 0, 0, 0));
    send_item(req(32767, -32768, -1, 4096, 0, 4096, 0));
    send_item(req(1, 1, 1, 32767, -32768, 0, 0));
    send_item(req(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(req(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(req(-1, -1, -1, 16384, -16384, 16384, -16384));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3)
        phase <= PH_SLOW_SOURCE;
      else if (i == 2 * RANDOM_ITEMS / 3)
        phase <= PH_FULL_RATE;
      send_item(random_request());
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
